>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

>>> rtl/ddmfe_pkg.sv
// ----------------------------------------------------------------------------
// ddmfe_pkg
// Types and constants shared by the wheel mixer and frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ddmfe_pkg;

  localparam int unsigned VelW     = 32;
  localparam int unsigned HtW      = 16;
  localparam int unsigned VmaxW    = 20;
  localparam int unsigned StepsW   = 16;
  localparam int unsigned IdW      = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned ProdW    = VelW + HtW;      // angular * half track
  localparam int unsigned SumW     = VelW + 1;        // wheel speed, no wrap
  localparam int unsigned NumW     = VmaxW + StepsW;  // magnitude * max steps
  localparam int unsigned DivStages = StepsW;         // one quotient bit per stage
  localparam int unsigned CntW     = 4;

  localparam logic [ByteW-1:0] StartMark = 8'hAA;
  localparam logic [ByteW-1:0] StepMode  = 8'h00;

  // Byte counter values across the two back-to-back frames.
  localparam logic [CntW-1:0] FrameLen      = 4'd6;
  localparam logic [CntW-1:0] LeftFirst     = 4'd0;
  localparam logic [CntW-1:0] LeftLast      = 4'd5;
  localparam logic [CntW-1:0] RightFirst    = 4'd6;
  localparam logic [CntW-1:0] RightLast     = 4'd11;

  typedef enum logic [CfgIdxW-1:0] {
    RegHalfTrack  = 3'd0,
    RegMaxSpeed   = 3'd1,
    RegMaxSteps   = 3'd2,
    RegLeftId     = 3'd3,
    RegRightId    = 3'd4,
    RegLeftFwd    = 3'd5,
    RegRightFwd   = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PosMark    = 3'd0,
    PosId      = 3'd1,
    PosMode    = 3'd2,
    PosDir     = 3'd3,
    PosStepsHi = 3'd4,
    PosStepsLo = 3'd5
  } frame_pos_e;

  // Lane 0 is the left wheel, lane 1 the right wheel.
  typedef struct packed {
    logic                       valid;
    logic [1:0]                 dir;
    logic [1:0][NumW-1:0]       num;
  } div_req_t;

  // Partial remainder plus a shared register that shifts numerator bits out
  // at the top and quotient bits in at the bottom.
  typedef struct packed {
    logic                       valid;
    logic [1:0]                 dir;
    logic [1:0][VmaxW-1:0]      rem;
    logic [1:0][StepsW-1:0]     lq;
  } div_stage_t;

  function automatic div_stage_t div_step(div_stage_t s, logic [VmaxW-1:0] d);
    div_stage_t     r;
    logic [VmaxW:0] trial;
    logic [VmaxW:0] diff;
    logic           ge;
    r = s;
    for (int k = 0; k < 2; k++) begin
      trial = {s.rem[k], s.lq[k][StepsW-1]};
      diff  = trial - {1'b0, d};
      ge    = (trial >= {1'b0, d});
      r.rem[k] = ge ? diff[VmaxW-1:0] : trial[VmaxW-1:0];
      r.lq[k]  = {s.lq[k][StepsW-2:0], ge};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ddmfe_intf.sv
// ----------------------------------------------------------------------------
// ddmfe interfaces
// Valid/ready channels for commands, frame bytes and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddmfe_cmd_if;
  logic                                valid;
  logic                                ready;
  logic signed [ddmfe_pkg::VelW-1:0]   linear_velocity;
  logic signed [ddmfe_pkg::VelW-1:0]   angular_velocity;
  modport source (output valid, output linear_velocity, output angular_velocity,
                  input ready);
  modport sink   (input valid, input linear_velocity, input angular_velocity,
                  output ready);
endinterface

interface ddmfe_frame_if;
  logic                         valid;
  logic                         ready;
  logic [ddmfe_pkg::ByteW-1:0]  frame_byte;
  logic                         last_byte;
  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface ddmfe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ddmfe_pkg::CfgIdxW-1:0]   index;
  logic [ddmfe_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/ddmfe_div.sv
// ----------------------------------------------------------------------------
// ddmfe_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ddmfe_div (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire ddmfe_pkg::div_req_t                in_i,
  input  wire logic [ddmfe_pkg::VmaxW-1:0]        divisor_i,
  output ddmfe_pkg::div_stage_t                   out_o
);

  ddmfe_pkg::div_stage_t st_in;
  ddmfe_pkg::div_stage_t st_prev [ddmfe_pkg::DivStages];
  ddmfe_pkg::div_stage_t st_q    [ddmfe_pkg::DivStages];

  // The quotient is known to fit in StepsW bits, so the top bits of the
  // numerator already form a remainder below the divisor.
  always_comb begin
    st_in.valid = in_i.valid;
    st_in.dir   = in_i.dir;
    for (int k = 0; k < 2; k++) begin
      st_in.rem[k] = in_i.num[k][ddmfe_pkg::NumW-1:ddmfe_pkg::StepsW];
      st_in.lq[k]  = in_i.num[k][ddmfe_pkg::StepsW-1:0];
    end
  end

  for (genvar s = 0; s < ddmfe_pkg::DivStages; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign st_prev[s] = st_in;
    end else begin : g_next
      assign st_prev[s] = st_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[s] <= '0;
      end else if (en_i) begin
        st_q[s] <= ddmfe_pkg::div_step(st_prev[s], divisor_i);
      end
    end
  end

  assign out_o = st_q[ddmfe_pkg::DivStages-1];

endmodule

`default_nettype wire

>>> rtl/diff_drive_motor_frame_encoder.sv
// ----------------------------------------------------------------------------
// diff_drive_motor_frame_encoder
// Mixes linear and angular velocity commands into left and right wheel
// step counts and streams them out as six-byte motor command frames.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload                                   Request means
// cmd_i     in   linear_velocity, angular_velocity (Q16.16) one command
// frame_o   out  frame_byte, last_byte                      one frame byte
// cfg_i     in   index, data                                one register write
//
// A command enters a 20-stage pipeline: multiply, wheel mix, magnitude clamp,
// scale by max_steps, then a 16-stage divider that yields one quotient bit
// per stage. The framer then sends one byte per cycle while frame_o.ready is
// high: twelve bytes for a command that drives both wheels, six for one wheel,
// none for a command with no steps, so the framer sets the sustained rate.
// Reset loads the register defaults and empties the pipeline; no clearing pass
// is needed. When the framer is busy and its last byte is not being taken, and
// the last stage holds a command, the whole pipeline holds and cmd_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module diff_drive_motor_frame_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ddmfe_cmd_if.sink        cmd_i,
  ddmfe_frame_if.source    frame_o,
  ddmfe_cfg_if.sink        cfg_i
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes are
  // dropped and wide data is truncated to the register width.
  // --------------------------------------------------------------------------
  logic [ddmfe_pkg::HtW-1:0]    half_track_q;
  logic [ddmfe_pkg::VmaxW-1:0]  max_speed_q;
  logic [ddmfe_pkg::StepsW-1:0] max_steps_q;
  logic [ddmfe_pkg::IdW-1:0]    left_id_q;
  logic [ddmfe_pkg::IdW-1:0]    right_id_q;
  logic                         left_fwd_q;
  logic                         right_fwd_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_track_q <= 16'd4915;
      max_speed_q  <= 20'd13107;
      max_steps_q  <= 16'd100;
      left_id_q    <= 8'd1;
      right_id_q   <= 8'd2;
      left_fwd_q   <= 1'b1;
      right_fwd_q  <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (ddmfe_pkg::cfg_reg_e'(cfg_i.index))
        ddmfe_pkg::RegHalfTrack: half_track_q <= cfg_i.data[ddmfe_pkg::HtW-1:0];
        ddmfe_pkg::RegMaxSpeed:  max_speed_q  <= cfg_i.data[ddmfe_pkg::VmaxW-1:0];
        ddmfe_pkg::RegMaxSteps:  max_steps_q  <= cfg_i.data[ddmfe_pkg::StepsW-1:0];
        ddmfe_pkg::RegLeftId:    left_id_q    <= cfg_i.data[ddmfe_pkg::IdW-1:0];
        ddmfe_pkg::RegRightId:   right_id_q   <= cfg_i.data[ddmfe_pkg::IdW-1:0];
        ddmfe_pkg::RegLeftFwd:   left_fwd_q   <= cfg_i.data[0];
        ddmfe_pkg::RegRightFwd:  right_fwd_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. All stages move together on adv; a stage whose valid
  // bit is low is a bubble and simply gets overwritten.
  // --------------------------------------------------------------------------
  logic adv;
  logic load;
  logic emit_done;
  logic frm_fire;
  logic em_free;

  ddmfe_pkg::div_stage_t dv;

  logic                               busy_q;
  logic [ddmfe_pkg::CntW-1:0]         cnt_q;
  logic [ddmfe_pkg::CntW-1:0]         end_q;

  assign frm_fire  = frame_o.valid && frame_o.ready;
  assign emit_done = busy_q && frame_o.ready && (cnt_q == end_q);
  assign em_free   = !busy_q || emit_done;
  assign adv       = !dv.valid || em_free;
  assign load      = dv.valid && em_free;
  assign cmd_i.ready = adv;

  // Stage A: angular velocity times half track (signed 32 x unsigned 16).
  // Both operands are sign-extended copies, so the real multiplier is 32x17.
  logic                              pa_valid_q;
  logic [ddmfe_pkg::VelW-1:0]        pa_lin_q;
  logic [ddmfe_pkg::ProdW-1:0]       pa_prod_q;
  logic signed [ddmfe_pkg::ProdW:0]  prod_full;

  assign prod_full = (ddmfe_pkg::ProdW+1)'(cmd_i.angular_velocity) *
                     (ddmfe_pkg::ProdW+1)'($signed({1'b0, half_track_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_valid_q <= 1'b0;
    end else if (adv) begin
      pa_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_lin_q  <= cmd_i.linear_velocity;
      pa_prod_q <= prod_full[ddmfe_pkg::ProdW-1:0];
    end
  end

  // Stage B: the top 32 product bits are the floor of the product over 2^16.
  // Wheel speeds are kept one bit wider so they never wrap.
  logic                              pb_valid_q;
  logic [1:0][ddmfe_pkg::SumW-1:0]   pb_spd_q;
  logic [ddmfe_pkg::SumW-1:0]        lin_ext;
  logic [ddmfe_pkg::SumW-1:0]        turn_ext;

  assign lin_ext  = {pa_lin_q[ddmfe_pkg::VelW-1], pa_lin_q};
  assign turn_ext = {pa_prod_q[ddmfe_pkg::ProdW-1],
                     pa_prod_q[ddmfe_pkg::ProdW-1:ddmfe_pkg::HtW]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_valid_q <= 1'b0;
    end else if (adv) begin
      pb_valid_q <= pa_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pb_spd_q[0] <= lin_ext - turn_ext;
      pb_spd_q[1] <= lin_ext + turn_ext;
    end
  end

  // Stage C: sign gives the direction, magnitude is clamped to max_speed.
  logic                                pc_valid_q;
  logic [1:0][ddmfe_pkg::VmaxW-1:0]    pc_mag_q;
  logic [1:0]                          pc_dir_q;
  logic [1:0][ddmfe_pkg::SumW-1:0]     abs_c;
  logic [1:0][ddmfe_pkg::VmaxW-1:0]    mag_c;
  logic [1:0]                          dir_c;
  logic [1:0]                          fwd_c;

  assign fwd_c = {right_fwd_q, left_fwd_q};

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      abs_c[k] = pb_spd_q[k][ddmfe_pkg::SumW-1] ? (~pb_spd_q[k] + 1'b1) : pb_spd_q[k];
      mag_c[k] = (abs_c[k] > {{(ddmfe_pkg::SumW-ddmfe_pkg::VmaxW){1'b0}}, max_speed_q})
                 ? max_speed_q : abs_c[k][ddmfe_pkg::VmaxW-1:0];
      dir_c[k] = fwd_c[k] ^ pb_spd_q[k][ddmfe_pkg::SumW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_valid_q <= 1'b0;
    end else if (adv) begin
      pc_valid_q <= pb_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pc_mag_q <= mag_c;
      pc_dir_q <= dir_c;
    end
  end

  // Stage D: scale by max_steps; the divider then takes off max_speed.
  logic                              pd_valid_q;
  logic [1:0]                        pd_dir_q;
  logic [1:0][ddmfe_pkg::NumW-1:0]   pd_num_q;
  ddmfe_pkg::div_req_t               pd_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pd_valid_q <= 1'b0;
    end else if (adv) begin
      pd_valid_q <= pc_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd_dir_q    <= pc_dir_q;
      pd_num_q[0] <= (ddmfe_pkg::NumW)'(pc_mag_q[0]) * (ddmfe_pkg::NumW)'(max_steps_q);
      pd_num_q[1] <= (ddmfe_pkg::NumW)'(pc_mag_q[1]) * (ddmfe_pkg::NumW)'(max_steps_q);
    end
  end

  assign pd_req = '{valid: pd_valid_q, dir: pd_dir_q, num: pd_num_q};

  ddmfe_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .in_i      (pd_req),
    .divisor_i (max_speed_q),
    .out_o     (dv)
  );

  // --------------------------------------------------------------------------
  // Framer. The byte counter runs over both frames: 0..5 is the left frame,
  // 6..11 the right one. A wheel with zero steps is skipped by starting or
  // ending the count past its frame; a command with no steps at all is
  // dropped on load without ever raising valid.
  // --------------------------------------------------------------------------
  logic [1:0][ddmfe_pkg::StepsW-1:0] steps_new;
  logic [1:0]                        en_new;
  logic [1:0][ddmfe_pkg::StepsW-1:0] steps_q;
  logic [1:0]                        dir_q;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      // A zero clamp would make every quotient bit one; it means no motion.
      steps_new[k] = (max_speed_q == '0) ? '0 : dv.lq[k];
      en_new[k]    = (steps_new[k] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      end_q  <= '0;
    end else if (load) begin
      busy_q <= |en_new;
      cnt_q  <= en_new[0] ? ddmfe_pkg::LeftFirst : ddmfe_pkg::RightFirst;
      end_q  <= en_new[1] ? ddmfe_pkg::RightLast : ddmfe_pkg::LeftLast;
    end else if (frm_fire) begin
      if (emit_done) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      steps_q <= steps_new;
      dir_q   <= dv.dir;
    end
  end

  logic                          wheel_sel;
  logic [ddmfe_pkg::CntW-1:0]    pos_full;
  logic [ddmfe_pkg::ByteW-1:0]   byte_c;
  logic [ddmfe_pkg::StepsW-1:0]  steps_sel;

  assign wheel_sel = (cnt_q >= ddmfe_pkg::FrameLen);
  assign pos_full  = wheel_sel ? (cnt_q - ddmfe_pkg::FrameLen) : cnt_q;
  assign steps_sel = steps_q[wheel_sel];

  always_comb begin
    unique case (ddmfe_pkg::frame_pos_e'(pos_full[2:0]))
      ddmfe_pkg::PosMark:    byte_c = ddmfe_pkg::StartMark;
      ddmfe_pkg::PosId:      byte_c = wheel_sel ? right_id_q : left_id_q;
      ddmfe_pkg::PosMode:    byte_c = ddmfe_pkg::StepMode;
      ddmfe_pkg::PosDir:     byte_c = {{(ddmfe_pkg::ByteW-1){1'b0}}, dir_q[wheel_sel]};
      ddmfe_pkg::PosStepsHi: byte_c = steps_sel[ddmfe_pkg::StepsW-1:ddmfe_pkg::ByteW];
      ddmfe_pkg::PosStepsLo: byte_c = steps_sel[ddmfe_pkg::ByteW-1:0];
      default:               byte_c = '0;
    endcase
  end

  assign frame_o.valid      = busy_q;
  assign frame_o.frame_byte = byte_c;
  assign frame_o.last_byte  = (cnt_q == end_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An accepted command always lands in the first stage.
  `ASSERT_PROP(a_accept_lands, clk_i, rst_ni, cmd_i.valid && cmd_i.ready |=> pa_valid_q)
  // The byte counter never runs past the end of the current command.
  `ASSERT_PROP(a_cnt_in_range, clk_i, rst_ni, busy_q |-> cnt_q <= end_q)
  // A byte that is not the last one is followed by the next byte.
  `ASSERT_PROP(a_cnt_steps, clk_i, rst_ni,
    frm_fire && !frame_o.last_byte |=> busy_q && (cnt_q == $past(cnt_q) + 4'd1))
  // A finished quotient waiting on the framer is not lost while stalled.
  `ASSERT_PROP(a_div_holds, clk_i, rst_ni, dv.valid && !adv |=> dv.valid)

endmodule

`default_nettype wire

>>> sim/diff_drive_motor_frame_encoder_tb.sv
// ----------------------------------------------------------------------------
// diff_drive_motor_frame_encoder_tb
// Self-checking bench for the wheel mixer and frame encoder. It sends velocity
// commands, predicts the frame bytes that each one must produce, and checks
// every byte in order under several register settings and handshake loads.
// ----------------------------------------------------------------------------
module diff_drive_motor_frame_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // An index that has no register behind it. A write there must change nothing.
  localparam logic [ddmfe_pkg::CfgIdxW-1:0] RegOutOfMap = 3'd7;

  // The pipeline is twenty stages deep, and the framer follows it.
  // After the last expected byte, this many quiet cycles make sure that no
  // command without frames is still in flight before a register is written.
  localparam int unsigned DrainCycles = 48;

  // Length of the long receiver hold-off. It is far longer than the pipeline,
  // so the block fills up and must drop its command ready.
  localparam int unsigned HoldLen = 300;

  typedef logic signed [ddmfe_pkg::VelW-1:0] vel_t;

  // One frame byte as it should appear on the output channel.
  typedef struct packed {
    logic [ddmfe_pkg::ByteW-1:0] frame_byte;
    logic                        last_byte;
  } frame_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ddmfe_cmd_if   cmd_if();
  ddmfe_frame_if frame_if();
  ddmfe_cfg_if   cfg_if();

  diff_drive_motor_frame_encoder DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .frame_o (frame_if),
    .cfg_i   (cfg_if)
  );

  // 4 ns clock period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Our copy of the register file. It follows every accepted register write,
  // masked to the register widths, and starts from the reset values.
  logic [ddmfe_pkg::HtW-1:0]    trk_half   = 16'd4915;
  logic [ddmfe_pkg::VmaxW-1:0]  spd_limit  = 20'd13107;
  logic [ddmfe_pkg::StepsW-1:0] step_scale = 16'd100;
  logic [ddmfe_pkg::IdW-1:0]    id_left    = 8'd1;
  logic [ddmfe_pkg::IdW-1:0]    id_right   = 8'd2;
  logic                         fwd_left   = 1'b1;
  logic                         fwd_right  = 1'b0;

  // Frame bytes that have been predicted but not yet seen, oldest first.
  frame_beat_t pending_beats[$];

  int unsigned errors        = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // The test raises hold_go to ask for one long receiver hold-off. The ready
  // process counts it out itself in hold_cnt and resets the count once the
  // test lowers hold_go again.
  bit          hold_go  = 1'b0;
  int unsigned hold_cnt = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Step count for one wheel: clamp the magnitude to the speed limit, then
  // scale it so that the limit maps onto the full step count. A zero limit
  // or a zero step scale gives zero steps, and so no frame.
  function automatic logic [ddmfe_pkg::StepsW-1:0] wheel_steps(longint wheel_speed);
    longint mag;
    if (spd_limit == '0) return '0;
    mag = (wheel_speed < 0) ? -wheel_speed : wheel_speed;
    if (mag > longint'(spd_limit)) mag = longint'(spd_limit);
    return (ddmfe_pkg::StepsW)'((mag * longint'(step_scale)) / longint'(spd_limit));
  endfunction

  // Mixes one command into both wheel speeds and queues the bytes that the
  // block must send for it: a left frame, then a right frame, each dropped
  // when its wheel has zero steps. The final byte of the command is flagged.
  task automatic predict_frames(vel_t lin, vel_t ang);
    longint                       turn;
    longint                       wheel_speed [2];
    logic [ddmfe_pkg::StepsW-1:0] steps;
    logic [ddmfe_pkg::IdW-1:0]    wheel_id;
    logic                         fwd;
    logic                         dir;
    frame_beat_t                  beats[$];
    // The shift of a signed product rounds toward minus infinity.
    turn = (longint'(ang) * longint'({1'b0, trk_half})) >>> 16;
    wheel_speed[0] = longint'(lin) - turn;
    wheel_speed[1] = longint'(lin) + turn;
    for (int k = 0; k < 2; k++) begin
      steps    = wheel_steps(wheel_speed[k]);
      wheel_id = (k == 0) ? id_left : id_right;
      fwd      = (k == 0) ? fwd_left : fwd_right;
      // A reverse speed sends the inverse of the wheel's forward polarity.
      dir      = (wheel_speed[k] < 0) ? ~fwd : fwd;
      if (steps != '0) begin
        beats.push_back('{ddmfe_pkg::StartMark, 1'b0});
        beats.push_back('{wheel_id, 1'b0});
        beats.push_back('{ddmfe_pkg::StepMode, 1'b0});
        beats.push_back('{(ddmfe_pkg::ByteW)'(dir), 1'b0});
        beats.push_back('{steps[15:8], 1'b0});
        beats.push_back('{steps[7:0], 1'b0});
      end
    end
    if (beats.size() != 0) beats[beats.size() - 1].last_byte = 1'b1;
    foreach (beats[i]) pending_beats.push_back(beats[i]);
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offers one command after a random gap and waits until it is taken. The
  // valid stays high on return, so a following command goes out back to back;
  // whoever stops sending lowers it.
  task automatic issue_command(vel_t lin, vel_t ang);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid            <= 1'b1;
    cmd_if.linear_velocity  <= lin;
    cmd_if.angular_velocity <= ang;
    do @(posedge clk_i); while (!cmd_if.ready);
    predict_frames(lin, ang);
  endtask

  // Stops sending and waits until every predicted byte has come out, then
  // lets the pipeline run empty of commands that produce no bytes.
  task automatic wait_quiet();
    cmd_if.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register write request. Our register copy follows it with the same
  // masking as the hardware; an index beyond the map is dropped.
  task automatic write_reg(logic [ddmfe_pkg::CfgIdxW-1:0] idx,
                           logic [ddmfe_pkg::CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      ddmfe_pkg::RegHalfTrack: trk_half   = value[ddmfe_pkg::HtW-1:0];
      ddmfe_pkg::RegMaxSpeed:  spd_limit  = value[ddmfe_pkg::VmaxW-1:0];
      ddmfe_pkg::RegMaxSteps:  step_scale = value[ddmfe_pkg::StepsW-1:0];
      ddmfe_pkg::RegLeftId:    id_left    = value[ddmfe_pkg::IdW-1:0];
      ddmfe_pkg::RegRightId:   id_right   = value[ddmfe_pkg::IdW-1:0];
      ddmfe_pkg::RegLeftFwd:   fwd_left   = value[0];
      ddmfe_pkg::RegRightFwd:  fwd_right  = value[0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Loads a full register setting. The caller has made sure the block is idle.
  task automatic set_config(logic [ddmfe_pkg::HtW-1:0] ht,
                            logic [ddmfe_pkg::VmaxW-1:0] vmax,
                            logic [ddmfe_pkg::StepsW-1:0] nsteps,
                            logic [ddmfe_pkg::IdW-1:0] lid,
                            logic [ddmfe_pkg::IdW-1:0] rid, logic lfwd, logic rfwd);
    write_reg(ddmfe_pkg::RegHalfTrack, (ddmfe_pkg::CfgDataW)'(ht));
    write_reg(ddmfe_pkg::RegMaxSpeed,  (ddmfe_pkg::CfgDataW)'(vmax));
    write_reg(ddmfe_pkg::RegMaxSteps,  (ddmfe_pkg::CfgDataW)'(nsteps));
    write_reg(ddmfe_pkg::RegLeftId,    (ddmfe_pkg::CfgDataW)'(lid));
    write_reg(ddmfe_pkg::RegRightId,   (ddmfe_pkg::CfgDataW)'(rid));
    write_reg(ddmfe_pkg::RegLeftFwd,   (ddmfe_pkg::CfgDataW)'(lfwd));
    write_reg(ddmfe_pkg::RegRightFwd,  (ddmfe_pkg::CfgDataW)'(rfwd));
  endtask

  // A velocity that mostly lands near the speed limit, so that the step
  // count varies, with some full-range values and the extremes mixed in.
  function automatic vel_t rand_vel(int unsigned span);
    vel_t v;
    case ($urandom_range(3))
      0: v = $urandom();
      3: begin
        case ($urandom_range(3))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          default: v = -32'sd1;
        endcase
      end
      default: v = $urandom_range(span);
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  // A random register setting. The speed limit is often kept small so that
  // ordinary commands give step counts below the clamp.
  task automatic set_random_config();
    logic [ddmfe_pkg::VmaxW-1:0] vmax;
    case ($urandom_range(2))
      0:       vmax = (ddmfe_pkg::VmaxW)'($urandom_range(255, 1));
      1:       vmax = (ddmfe_pkg::VmaxW)'($urandom_range(1048575, 1));
      default: vmax = (ddmfe_pkg::VmaxW)'($urandom_range(200000, 1000));
    endcase
    set_config((ddmfe_pkg::HtW)'($urandom_range(65535)), vmax,
               (ddmfe_pkg::StepsW)'($urandom_range(65535, 1)),
               (ddmfe_pkg::IdW)'($urandom_range(255)),
               (ddmfe_pkg::IdW)'($urandom_range(255)),
               1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // --------------------------------------------------------------------------
  // Receiver
  // --------------------------------------------------------------------------

  // Drives the frame ready: a long hold-off when the test asks for one,
  // otherwise random stalls at the current rate.
  initial begin
    frame_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_go) hold_cnt = 0;
      if (hold_go && hold_cnt < HoldLen) begin
        hold_cnt++;
        frame_if.ready <= 1'b0;
      end else begin
        frame_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Every accepted frame byte is compared with the oldest prediction.
  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni && frame_if.valid && frame_if.ready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected frame byte: frame_byte actual %02h last_byte actual %0b",
               frame_if.frame_byte, frame_if.last_byte);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (frame_if.frame_byte !== want.frame_byte) begin
          $error("frame_byte mismatch: expected %02h actual %02h",
                 want.frame_byte, frame_if.frame_byte);
          errors++;
        end
        if (frame_if.last_byte !== want.last_byte) begin
          $error("last_byte mismatch: expected %0b actual %0b",
                 want.last_byte, frame_if.last_byte);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Commands at the reset setting: extreme velocities, a wheel that exactly
  // cancels to zero, speeds just under and just over one step, and a tiny
  // negative turn whose product rounds down to minus one.
  task automatic test_reset_defaults();
    issue_command(32'sd0, 32'sd0);
    issue_command(32'sh7FFF_FFFF, 32'sd0);
    issue_command(32'sh8000_0000, 32'sd0);
    issue_command(32'sd0, 32'sh7FFF_FFFF);
    issue_command(32'sd0, 32'sh8000_0000);
    issue_command(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    issue_command(32'sh8000_0000, 32'sh8000_0000);
    // Left wheel mixes to exactly zero; only the right frame goes out.
    issue_command(32'sd4915, 32'sd65536);
    issue_command(32'sd132, 32'sd0);
    // Both wheels round to zero steps, so this command sends nothing.
    issue_command(32'sd131, 32'sd0);
    issue_command(-32'sd132, 32'sd0);
    issue_command(32'sd0, -32'sd1);
    wait_quiet();
  endtask

  // Extreme register values. The half-track write carries bits above its
  // width, the polarity write carries a set upper bit that must be dropped,
  // and a write to an unmapped index must have no effect at all.
  task automatic test_register_extremes();
    write_reg(ddmfe_pkg::RegHalfTrack, 20'hFFFFF);
    write_reg(ddmfe_pkg::RegMaxSpeed,  20'd1);
    write_reg(ddmfe_pkg::RegMaxSteps,  20'd65535);
    write_reg(ddmfe_pkg::RegLeftId,    20'd255);
    write_reg(ddmfe_pkg::RegRightId,   20'd0);
    write_reg(ddmfe_pkg::RegLeftFwd,   20'hFFFFE);
    write_reg(ddmfe_pkg::RegRightFwd,  20'd1);
    write_reg(RegOutOfMap,             20'hFFFFF);
    issue_command(32'sd1, 32'sd0);
    issue_command(-32'sd1, 32'sd0);
    // The turn rounds to zero here, and to minus one with a negative rate.
    issue_command(32'sd0, 32'sd1);
    issue_command(32'sd0, -32'sd1);
    issue_command(32'sh8000_0000, 32'sh7FFF_FFFF);
    wait_quiet();

    // Widest speed limit with a single step: only a speed at or above the limit reaches it.
    write_reg(ddmfe_pkg::RegMaxSpeed, 20'hFFFFF);
    write_reg(ddmfe_pkg::RegMaxSteps, 20'd1);
    issue_command(32'sd1048575, 32'sd0);
    issue_command(32'sd1048574, 32'sd0);
    issue_command(32'sh8000_0000, 32'sd0);
    wait_quiet();
  endtask

  // A zero speed limit and a zero step scale both silence every wheel.
  task automatic test_disabled_scaling();
    write_reg(ddmfe_pkg::RegMaxSpeed, 20'd0);
    write_reg(ddmfe_pkg::RegMaxSteps, 20'd100);
    issue_command(32'sh7FFF_FFFF, 32'sd12345);
    issue_command(-32'sd70000, 32'sd0);
    wait_quiet();
    write_reg(ddmfe_pkg::RegMaxSpeed, 20'd13107);
    write_reg(ddmfe_pkg::RegMaxSteps, 20'd0);
    issue_command(32'sh8000_0000, 32'sd0);
    issue_command(32'sd20000, -32'sd5000);
    wait_quiet();
  endtask

  // Random commands under a fresh random setting and one idling pattern.
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall,
                                     int unsigned count);
    set_random_config();
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (count) begin
      issue_command(rand_vel(2 * spd_limit + 2), rand_vel(2 * spd_limit + 2));
    end
    wait_quiet();
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // The receiver holds off far longer than the pipeline is deep while the
  // sender keeps offering requests back to back. Thirty requests are more
  // than the pipeline and the framer can hold, so the block fills and stalls
  // its input. After those thirty, the sender pauses until every byte is out.
  task automatic test_backpressure();
    set_config(16'd4915, 20'd13107, 16'd100, 8'd1, 8'd2, 1'b1, 1'b0);
    hold_go = 1'b1;
    repeat (30) issue_command(rand_vel(30000), rand_vel(30000));
    wait_quiet();
    hold_go = 1'b0;
    stall_pct = 30;
    repeat (10) issue_command(rand_vel(30000), rand_vel(30000));
    wait_quiet();
    stall_pct = 0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni                  <= 1'b0;
    cmd_if.valid            <= 1'b0;
    cmd_if.linear_velocity  <= '0;
    cmd_if.angular_velocity <= '0;
    cfg_if.valid            <= 1'b0;
    cfg_if.index            <= '0;
    cfg_if.data             <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_disabled_scaling();
    test_random_traffic(0, 0, 18);
    test_random_traffic(80, 0, 18);
    test_random_traffic(0, 80, 18);
    test_random_traffic(18, 18, 18);
    test_backpressure();

    // Every prediction has been matched; give the block time to show any
    // stray byte before the verdict.
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard limit on the run, many times the slowest correct run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
